/* src/bit_stack_buffer_top_defines.svh */
// ---------------------------------------------------------------------------
// bit_stack_buffer_top_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef BIT_STACK_BUFFER_TOP_DEFINES_SVH
`define BIT_STACK_BUFFER_TOP_DEFINES_SVH

// assertion that is switched off while reset is active
`define BSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also samples during reset
`define BSB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bsb_pkg.sv */
// ---------------------------------------------------------------------------
// bsb_pkg
// types, codes and constants of the bit stack buffer
// ---------------------------------------------------------------------------
package bsb_pkg;

  // store geometry: bits are kept eight to a word, lane = position[2:0]
  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned WORDS    = CAPACITY / 8;
  localparam int unsigned WA_W     = $clog2(WORDS);

  // command codes
  typedef enum logic [2:0] {
    CMD_PUSH_BIT  = 3'd0,
    CMD_PUSH_MSB  = 3'd1,
    CMD_PUSH_LSB  = 3'd2,
    CMD_POP       = 3'd3,
    CMD_SET       = 3'd4,
    CMD_READ_BIT  = 3'd5,
    CMD_READ_BYTE = 3'd6
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // memory port request
  typedef struct packed {
    logic            we;
    logic [WA_W-1:0] waddr;
    logic [7:0]      wmask;
    logic [7:0]      wdata;
    logic            re;
    logic [WA_W-1:0] raddr;
  } mem_req_t;

  // bit order swap of one byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

/* src/bsb_mem.sv */
// ---------------------------------------------------------------------------
// bsb_mem
// word store with a bit-masked write port and two registered read ports
// (the addressed word and the one after it)
// ---------------------------------------------------------------------------
module bsb_mem import bsb_pkg::*; (
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rd0_o,
  output logic [7:0] rd1_o
);

  logic [7:0]      mem_q [WORDS];
  logic [WA_W-1:0] raddr1;

  assign raddr1 = req_i.raddr + WA_W'(1);

  // masked write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int b = 0; b < 8; b++) begin
        if (req_i.wmask[b]) mem_q[req_i.waddr][b] <= req_i.wdata[b];
      end
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd0_o <= mem_q[req_i.raddr];
      rd1_o <= mem_q[raddr1];
    end
  end

endmodule

/* src/bsb_align.sv */
// ---------------------------------------------------------------------------
// bsb_align
// shared 16-bit funnel shifter: places a bit stream at its lane offset for
// writes and pulls eight bits out of a two-word window for reads
// ---------------------------------------------------------------------------
module bsb_align import bsb_pkg::*; (
  input  logic [15:0] data_i,
  input  logic [2:0]  amt_i,
  input  logic        left_i,
  output logic [15:0] data_o
);

  // shift in either direction by the lane offset
  always_comb begin
    if (left_i) begin
      data_o = data_i << amt_i;
    end else begin
      data_o = data_i >> amt_i;
    end
  end

endmodule

/* src/bit_stack_buffer_top.sv */
// ---------------------------------------------------------------------------
// bit_stack_buffer_top
// bit-addressed stack store with a length counter, one result per command
// ---------------------------------------------------------------------------
//  channel   | direction | handshake             | payload
//  command   | in        | start, busy           | cmd_i, bit_index_i, bit_in_i, byte_in_i
//  result    | out       | done_o (one cycle)    | status_o, bit_out_o, byte_out_o,
//            |           |                       | fill_length_o
//
//  A command is taken when start is high and busy is low; it runs the access and finish
//  states, its result strobes as finish is left and busy drops in that same cycle, so no
//  command is taken before the last result. A byte push across a word boundary adds a
//  high-word state, because the word store has a single write port and both words are
//  written. Reset clears the length and the sequencer; the store itself is not cleared.
//  The result receiver cannot stall: done_o is a one-cycle pulse.
// ---------------------------------------------------------------------------
module bit_stack_buffer_top import bsb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       cmd_i,
  input  logic [IDX_W-1:0] bit_index_i,
  input  logic             bit_in_i,
  input  logic [7:0]       byte_in_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             bit_out_o,
  output logic [7:0]       byte_out_o,
  output logic [CNT_W-1:0] fill_length_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_HIGH   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [2:0]       cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic             bin_q;
  logic [7:0]       byte_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          status_q, status_d;
  logic             done_q;
  logic             bit_out_q, bit_out_d;
  logic [7:0]       byte_out_q, byte_out_d;
  logic [7:0]       hi_data_q;
  logic [7:0]       hi_mask_q;
  logic [WA_W-1:0]  hi_addr_q;

  logic             accept;
  logic             is_push_byte;
  logic [IDX_W-1:0] pos;
  logic [7:0]       stream;
  logic [15:0]      mask16;
  logic [15:0]      al_in, al_out;
  logic             al_left;
  logic             wr_ok;
  logic [CNT_W-1:0] idx_ext;
  mem_req_t         mem_req;
  logic [7:0]       rd0, rd1;

  assign accept       = start && !busy;
  assign busy         = (state_q != S_IDLE);
  assign is_push_byte = (cmd_q == CMD_PUSH_MSB) || (cmd_q == CMD_PUSH_LSB);
  assign idx_ext      = {1'b0, idx_q};

  // target position and bit stream of the command
  always_comb begin
    pos    = idx_q;
    stream = 8'h00;
    unique case (cmd_q)
      CMD_PUSH_BIT: begin
        pos    = cnt_q[IDX_W-1:0];
        stream = {7'b0, bin_q};
      end
      CMD_PUSH_MSB: begin
        pos    = cnt_q[IDX_W-1:0];
        stream = rev8(byte_q);
      end
      CMD_PUSH_LSB: begin
        pos    = cnt_q[IDX_W-1:0];
        stream = byte_q;
      end
      CMD_POP: pos = cnt_q[IDX_W-1:0] - IDX_W'(1);
      CMD_SET: stream = {7'b0, bin_q};
      default: ;
    endcase
  end

  // write lane mask over the two-word window
  assign mask16 = (is_push_byte ? 16'h00FF : 16'h0001) << pos[2:0];

  // shared shifter: write alignment in access, read extraction in finish
  always_comb begin
    if (state_q == S_FINISH) begin
      al_in   = {rd1, rd0};
      al_left = 1'b0;
    end else begin
      al_in   = {8'h00, stream};
      al_left = 1'b1;
    end
  end

  bsb_align u_align (
    .data_i (al_in),
    .amt_i  (pos[2:0]),
    .left_i (al_left),
    .data_o (al_out)
  );

  // status and length update of the command
  always_comb begin
    status_d = STAT_OK;
    cnt_d    = cnt_q;
    wr_ok    = 1'b0;
    unique case (cmd_q)
      CMD_PUSH_BIT: begin
        if (cnt_q >= CNT_W'(CAPACITY)) begin
          status_d = STAT_FULL;
        end else begin
          wr_ok = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      CMD_PUSH_MSB, CMD_PUSH_LSB: begin
        if (cnt_q > CNT_W'(CAPACITY - 8)) begin
          status_d = STAT_FULL;
        end else begin
          wr_ok = 1'b1;
          cnt_d = cnt_q + CNT_W'(8);
        end
      end
      CMD_POP: begin
        if (cnt_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          wr_ok = 1'b1;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      CMD_SET: begin
        if (idx_ext >= cnt_q) status_d = STAT_RANGE;
        else wr_ok = 1'b1;
      end
      CMD_READ_BIT: begin
        if (idx_ext >= cnt_q) status_d = STAT_RANGE;
      end
      CMD_READ_BYTE: begin
        if (idx_ext + CNT_W'(8) > cnt_q) status_d = STAT_RANGE;
      end
      default: ;
    endcase
  end

  // memory request: low word in access, high word in the extra cycle
  always_comb begin
    mem_req       = '0;
    mem_req.raddr = idx_q[IDX_W-1:3];
    mem_req.re    = (state_q == S_ACCESS);
    if (state_q == S_ACCESS) begin
      mem_req.we    = wr_ok;
      mem_req.waddr = pos[IDX_W-1:3];
      mem_req.wmask = mask16[7:0];
      mem_req.wdata = al_out[7:0];
    end else if (state_q == S_HIGH) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = hi_addr_q;
      mem_req.wmask = hi_mask_q;
      mem_req.wdata = hi_data_q;
    end
  end

  bsb_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rd0_o (rd0),
    .rd1_o (rd1)
  );

  // read results
  always_comb begin
    bit_out_d  = 1'b0;
    byte_out_d = 8'h00;
    if (status_q == STAT_OK) begin
      if (cmd_q == CMD_READ_BIT) bit_out_d = rd0[idx_q[2:0]];
      if (cmd_q == CMD_READ_BYTE) byte_out_d = rev8(al_out[7:0]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_ACCESS;
      S_ACCESS: begin
        if (wr_ok && is_push_byte && (pos[2:0] != 3'd0)) state_d = S_HIGH;
        else state_d = S_FINISH;
      end
      S_HIGH:   state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
      if (state_q == S_ACCESS) cnt_q <= cnt_d;
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      idx_q  <= bit_index_i;
      bin_q  <= bit_in_i;
      byte_q <= byte_in_i;
    end
  end

  // access-cycle results and high-word write data
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACCESS) begin
      status_q  <= status_d;
      hi_data_q <= al_out[15:8];
      hi_mask_q <= mask16[15:8];
      hi_addr_q <= pos[IDX_W-1:3] + WA_W'(1);
    end
  end

  // result word registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH) begin
      bit_out_q  <= bit_out_d;
      byte_out_q <= byte_out_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign bit_out_o     = bit_out_q;
  assign byte_out_o    = byte_out_q;
  assign fill_length_o = cnt_q;

endmodule

/* src/bsb_checker.sv */
// ---------------------------------------------------------------------------
// bsb_checker
// port-level checks of the bit stack buffer, bound to the top level
// ---------------------------------------------------------------------------
`include "bit_stack_buffer_top_defines.svh"

module bsb_checker import bsb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic [CNT_W-1:0] fill_length_o
);

  // reset leaves the block idle with no result pending
  `BSB_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> !done_o && !busy, "not idle after reset")

  // an accepted command makes the block busy
  `BSB_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "no busy after accept")

  // a result strobe ends the command and is never doubled
  `BSB_ASSERT(a_done_single, clk_i, rst_ni, done_o |-> !busy ##1 !done_o, "bad result strobe")

  // length stays within the store
  `BSB_ASSERT(a_len_cap, clk_i, rst_ni, fill_length_o <= CNT_W'(CAPACITY), "length over capacity")

  // a full status only comes with less than a byte of room
  `BSB_ASSERT(a_full_len, clk_i, rst_ni,
    done_o && status_o == STAT_FULL |-> fill_length_o > CNT_W'(CAPACITY - 8), "false full")

endmodule

bind bit_stack_buffer_top bsb_checker u_bsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .fill_length_o (fill_length_o)
);
